// File: src/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SAL_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SAL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// File: src/sal_pkg.sv
// Shared types, codes and constants of the shifting array list.
`timescale 1ns / 1ps
`default_nettype none
package sal_pkg;

	localparam int DEF_CAPACITY   = 16;
	localparam int DEF_DATA_WIDTH = 32;

	// The find scan examines this many cells per cycle.
	localparam int SCAN_GROUP = 8;
	localparam int SCAN_GW    = 3;

	typedef enum logic [2:0] {
		ACT_PUSH_BACK  = 3'd0,
		ACT_POP_BACK   = 3'd1,
		ACT_PUSH_FRONT = 3'd2,
		ACT_POP_FRONT  = 3'd3,
		ACT_INSERT     = 3'd4,
		ACT_ERASE      = 3'd5,
		ACT_FIND       = 3'd6
	} action_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_BADPOS   = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		SH_HOLD,
		SH_OPEN,
		SH_CLOSE
	} shift_op_t;

	typedef struct packed {
		logic [2:0]         action;
		logic signed [31:0] value;
		logic [4:0]         position;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [3:0] found_index;
		logic [4:0] entry_count;
	} rsp_t;

	typedef struct packed {
		logic hit;
		logic empty;
	} scan_stat_t;

endpackage
`default_nettype wire

// File: src/sal_cell.sv
// One storage cell of the list: holds one entry, shifts with its neighbors, compares.
`timescale 1ns / 1ps
`default_nettype none
module sal_cell
	import sal_pkg::*;
#(
	parameter int DATA_WIDTH = DEF_DATA_WIDTH,
	parameter int IW         = 4,
	parameter int CW         = 5,
	parameter int INDEX      = 0
) (
	input  wire logic                  clk,
	input  wire shift_op_t             op,
	input  wire logic [IW-1:0]         at,
	input  wire logic [DATA_WIDTH-1:0] load_value,
	input  wire logic [DATA_WIDTH-1:0] prev_data,
	input  wire logic [DATA_WIDTH-1:0] next_data,
	input  wire logic [CW-1:0]         count,
	input  wire logic [DATA_WIDTH-1:0] find_value,
	output logic      [DATA_WIDTH-1:0] data,
	output logic                       match
);

	localparam logic [IW-1:0] MY_IDX = IW'(INDEX);
	localparam logic [CW-1:0] MY_CNT = CW'(INDEX);

	logic [DATA_WIDTH-1:0] data_q;

	always_ff @(posedge clk) begin
		case (op)
			SH_OPEN: begin
				if (MY_IDX > at) begin
					data_q <= prev_data;
				end else if (MY_IDX == at) begin
					data_q <= load_value;
				end
			end
			SH_CLOSE: begin
				if (MY_IDX >= at) begin
					data_q <= next_data;
				end
			end
			default: begin
			end
		endcase
	end

	assign data  = data_q;
	// Only occupied cells may report a match.
	assign match = (data_q == find_value) && (MY_CNT < count);

endmodule
`default_nettype wire

// File: src/sal_scan.sv
// First-match search over the registered match bits, one group of cells per cycle.
`timescale 1ns / 1ps
`default_nettype none
module sal_scan
	import sal_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY,
	parameter int IW       = 4
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                load,
	input  wire logic [CAPACITY-1:0] match,
	output scan_stat_t               stat,
	output logic      [IW-1:0]       hit_index
);

	localparam int NGROUPS = (CAPACITY + SCAN_GROUP - 1) / SCAN_GROUP;
	localparam int VW      = NGROUPS * SCAN_GROUP;

	logic [VW-1:0]      vec_q;
	logic [IW-1:0]      base_q;
	logic [SCAN_GW-1:0] first;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vec_q  <= '0;
			base_q <= '0;
		end else if (load) begin
			vec_q  <= VW'(match);
			base_q <= '0;
		end else begin
			vec_q  <= vec_q >> SCAN_GROUP;
			base_q <= base_q + IW'(SCAN_GROUP);
		end
	end

	// Lowest set bit of the current group wins.
	always_comb begin
		first = '0;
		for (int k = SCAN_GROUP - 1; k >= 0; k--) begin
			if (vec_q[k]) begin
				first = SCAN_GW'(k);
			end
		end
	end

	assign stat      = '{hit: |vec_q[SCAN_GROUP-1:0], empty: (vec_q == '0)};
	assign hit_index = base_q + IW'(first);

endmodule
`default_nettype wire

// File: src/shifting_array_list.sv
// Top level of the shifting array list: request decode, cell row and find scan.
`timescale 1ns / 1ps
`default_nettype none
// Ordered list of signed DATA_WIDTH-bit values in a row of CAPACITY cells.
// A request beat is taken at a rising edge with start high and busy low. It
// carries an action (push/pop at either end, insert or erase at a position,
// or find), a value and a position. Each request yields exactly one result
// beat: status, index of the first match for a find, and the entry count after
// the request. The result is shown for one cycle with done high; the receiver
// cannot stall it, so it must take it in that cycle.
// Every action except find completes in the accept cycle, and its result
// appears the next cycle with busy staying low, so one request per cycle is
// taken. A find compares all cells in parallel in the accept cycle, then
// searches the registered match bits eight cells per cycle, holding busy until
// it finds a match or no match bits remain; its result appears as busy falls.
// Shifts for insert, erase and the front operations happen in the accept
// cycle, each cell taking its neighbor's entry. Reset clears the count and
// control state, not the cells; cells above the count are never observed.
module shifting_array_list
	import sal_pkg::*;
#(
	parameter int CAPACITY   = DEF_CAPACITY,
	parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire req_t request,
	output logic      done,
	output rsp_t      result
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > 5) ? CW : 5;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	typedef enum logic {
		S_IDLE,
		S_SCAN
	} state_t;

	state_t      state_q;
	logic        done_q;
	rsp_t        result_q;
	logic [CW-1:0] count_q;

	logic                  accept;
	logic                  is_find;
	logic [DATA_WIDTH-1:0] value_ext;
	logic [PW-1:0]         pos_ext;
	logic [PW-1:0]         cnt_ext;
	logic                  full;
	logic                  empty;
	status_t               status_d;
	shift_op_t             op_d;
	shift_op_t             cell_op;
	logic [IW-1:0]         at_d;
	logic [CW-1:0]         count_d;

	logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
	logic [CAPACITY-1:0]   match_vec;
	scan_stat_t            scan_stat;
	logic [IW-1:0]         hit_index;

	assign busy    = (state_q == S_SCAN);
	assign accept  = start && !busy;
	assign is_find = (request.action == ACT_FIND);

	// The request value is sign-extended or truncated to the stored width.
	assign value_ext = DATA_WIDTH'($signed(request.value));
	assign pos_ext   = PW'(request.position);
	assign cnt_ext   = PW'(count_q);
	assign full      = (count_q == CAP_C);
	assign empty     = (count_q == '0);

	// Decode the request into a status, a shift for the cell row and the
	// new count. A failing request leaves the row and count untouched.
	always_comb begin
		status_d = ST_OK;
		op_d     = SH_HOLD;
		at_d     = '0;
		count_d  = count_q;
		case (request.action)
			ACT_PUSH_BACK: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					op_d    = SH_OPEN;
					at_d    = IW'(count_q);
					count_d = count_q + CW'(1);
				end
			end
			ACT_POP_BACK: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					count_d = count_q - CW'(1);
				end
			end
			ACT_PUSH_FRONT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					op_d    = SH_OPEN;
					count_d = count_q + CW'(1);
				end
			end
			ACT_POP_FRONT: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					op_d    = SH_CLOSE;
					count_d = count_q - CW'(1);
				end
			end
			ACT_INSERT: begin
				// The position check takes precedence over the full check.
				if (pos_ext > cnt_ext) begin
					status_d = ST_BADPOS;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					op_d    = SH_OPEN;
					at_d    = IW'(request.position);
					count_d = count_q + CW'(1);
				end
			end
			ACT_ERASE: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else if (pos_ext >= cnt_ext) begin
					status_d = ST_BADPOS;
				end else begin
					op_d    = SH_CLOSE;
					at_d    = IW'(request.position);
					count_d = count_q - CW'(1);
				end
			end
			default: begin
				// Find is resolved by the scan; the unused code is ignored.
			end
		endcase
	end

	assign cell_op = accept ? op_d : SH_HOLD;

	// The row of cells. Each cell sees its lower and upper neighbor; cell 0's lower
	// input is never selected, and the top cell keeps its own entry on a close.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] prev_w;
		logic [DATA_WIDTH-1:0] next_w;

		if (i == 0) begin : g_first
			assign prev_w = value_ext;
		end else begin : g_prev
			assign prev_w = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign next_w = cell_data[i];
		end else begin : g_next
			assign next_w = cell_data[i+1];
		end

		sal_cell #(
			.DATA_WIDTH(DATA_WIDTH),
			.IW        (IW),
			.CW        (CW),
			.INDEX     (i)
		) u_cell (
			.clk       (clk),
			.op        (cell_op),
			.at        (at_d),
			.load_value(value_ext),
			.prev_data (prev_w),
			.next_data (next_w),
			.count     (count_q),
			.find_value(value_ext),
			.data      (cell_data[i]),
			.match     (match_vec[i])
		);
	end

	sal_scan #(
		.CAPACITY(CAPACITY),
		.IW      (IW)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept && is_find),
		.match    (match_vec),
		.stat     (scan_stat),
		.hit_index(hit_index)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			done_q   <= 1'b0;
			result_q <= '0;
			count_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (is_find) begin
							state_q <= S_SCAN;
						end else begin
							count_q              <= count_d;
							done_q               <= 1'b1;
							result_q.status      <= status_d;
							result_q.found_index <= '0;
							result_q.entry_count <= 5'(count_d);
						end
					end
				end
				S_SCAN: begin
					if (scan_stat.hit) begin
						state_q              <= S_IDLE;
						done_q               <= 1'b1;
						result_q.status      <= ST_OK;
						result_q.found_index <= 4'(hit_index);
						result_q.entry_count <= 5'(count_q);
					end else if (scan_stat.empty) begin
						state_q              <= S_IDLE;
						done_q               <= 1'b1;
						result_q.status      <= ST_NOTFOUND;
						result_q.found_index <= '0;
						result_q.entry_count <= 5'(count_q);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
`default_nettype wire

// File: src/sal_checker.sv
// Port-level checks of the shifting array list and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sal_port_checks
	import sal_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire req_t request,
	input wire logic done,
	input wire rsp_t result
);

	logic req_take;

	assign req_take = start && !busy;

	// A result beat always leaves the block ready for a new request.
	`SAL_ASSERT_NOW(a_done_not_busy, clk, arst_n, done, !busy)

	// Every accepted request other than find answers in the next cycle.
	`SAL_ASSERT_NEXT(a_quick_answer, clk, arst_n, req_take && (request.action != ACT_FIND), done && !busy)

	// An accepted find always leaves the block busy, with no result, in the next cycle.
	`SAL_ASSERT_NEXT(a_find_busy, clk, arst_n, req_take && (request.action == ACT_FIND), busy && !done)

	// A nonzero index comes only with a successful find.
	`SAL_ASSERT_NOW(a_index_ok, clk, arst_n, done && (result.found_index != 4'd0), result.status == ST_OK)

endmodule

bind shifting_array_list sal_port_checks u_sal_port_checks (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.request(request),
	.done   (done),
	.result (result)
);
`default_nettype wire
